// ===== hw/rtl/bmpx_pkg.sv =====
// Package for the BMP pixel extractor: limits, header constants, phase and
// status codes, and the result item type. No dependencies.
package bmpx_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PROD_W = 16 + COL_W;

  localparam logic [7:0]  MAGIC_B        = 8'h42;
  localparam logic [7:0]  MAGIC_M        = 8'h4D;
  localparam logic [31:0] OFFSET_MIN     = 32'd54;
  localparam logic [31:0] CORE_HDR_MAX   = 32'd12;
  localparam logic [15:0] BPP_MIN        = 16'd24;
  localparam logic [3:0]  FILE_HDR_LAST  = 4'd13;
  localparam logic [5:0]  FILE_HDR_BYTES = 6'd14;
  localparam logic [5:0]  INFO_HDR_LAST  = 6'd39;
  localparam int          ROW_BYTES_MAX  = 65535;
  localparam int          ROW_WORDS_MAX  = ROW_BYTES_MAX / 4;

  typedef enum logic [2:0] {
    PH_FILE,
    PH_INFO,
    PH_SKIP,
    PH_PIX,
    PH_DRAIN
  } phase_t;

  typedef enum logic [2:0] {
    ST_PIXEL       = 3'd0,
    ST_SHORT_HDR   = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_OFFSET  = 3'd3,
    ST_COMPRESSED  = 3'd4,
    ST_BAD_SIZE    = 3'd5,
    ST_SHORT_PIXEL = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] column;
    logic [11:0] image_row;
    logic        last_pixel;
    status_t     status;
  } result_t;

endpackage

// ===== hw/rtl/bmpx_parser.sv =====
// Header parser and pixel walker: holds the file state registers and forms
// at most one result item per accepted byte. Depends on bmpx_pkg.
module bmpx_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic [7:0]        file_byte,
  input  logic              file_end,
  output logic              res_valid,
  output bmpx_pkg::result_t res
);
  import bmpx_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [31:0]        pos_r, pos_nxt;
  logic [31:0]        offset_r, offset_nxt;
  logic [31:0]        hdr_size_r, hdr_size_nxt;
  logic [31:0]        width_r, width_nxt;
  logic [31:0]        height_r, height_nxt;
  logic [15:0]        bpp_r, bpp_nxt;
  logic [15:0]        row_bytes_r, row_bytes_nxt;
  logic [15:0]        bir_r, bir_nxt;
  logic [ROW_W-1:0]   stored_row_r, stored_row_nxt;
  logic [7:0]         blue_r, blue_nxt;
  logic [7:0]         green_r, green_nxt;
  logic               comp_r, comp_nxt;
  logic [12:0]        sub_r, sub_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;

  logic [31:0]        pos_inc;
  logic [5:0]         info_idx;
  logic               hdr_small;
  logic [PROD_W-1:0]  rb_prod;
  logic [PROD_W:0]    rb_sum;
  logic [PROD_W-5:0]  rb_words;
  logic               size_bad;
  logic [COL_W-1:0]   width_c;
  logic [HGT_W-1:0]   height_h;
  logic [HGT_W-1:0]   srow_h;
  logic [12:0]        bpx;
  logic               in_pix;
  logic               sub_last;
  logic               row_end;
  logic               pixel;
  logic               complete;
  status_t            status;

  assign pos_inc   = pos_r + 32'd1;
  assign info_idx  = pos_r[5:0] - FILE_HDR_BYTES;
  assign hdr_small = (hdr_size_r <= CORE_HDR_MAX);
  assign width_c   = width_r[COL_W-1:0];
  assign height_h  = height_r[HGT_W-1:0];
  assign srow_h    = HGT_W'(stored_row_r);
  assign bpx       = bpp_r[15:3];

  assign rb_prod  = PROD_W'(bpp_r) * PROD_W'(width_c);
  assign rb_sum   = {1'b0, rb_prod} + (PROD_W + 1)'(31);
  assign rb_words = rb_sum[PROD_W:5];
  assign size_bad = (width_r == '0) || (height_r == '0) || (bpp_r < BPP_MIN)
                 || (bpp_r[2:0] != 3'd0) || (width_r > 32'(MAX_WIDTH))
                 || (height_r > 32'(MAX_HEIGHT))
                 || (rb_words > (PROD_W - 4)'(ROW_WORDS_MAX));

  assign in_pix   = (col_r < width_c);
  assign sub_last = ({1'b0, sub_r} + 14'd1) == {1'b0, bpx};
  assign row_end  = ({1'b0, bir_r} + 17'd1) >= {1'b0, row_bytes_r};
  assign pixel    = in_pix && (sub_r == 13'd2);

  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    offset_nxt     = offset_r;
    hdr_size_nxt   = hdr_size_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    bpp_nxt        = bpp_r;
    row_bytes_nxt  = row_bytes_r;
    bir_nxt        = bir_r;
    stored_row_nxt = stored_row_r;
    blue_nxt       = blue_r;
    green_nxt      = green_r;
    comp_nxt       = comp_r;
    sub_nxt        = sub_r;
    col_nxt        = col_r;
    status         = ST_PIXEL;
    complete       = 1'b0;
    res_valid      = 1'b0;
    res            = '0;

    if (in_accept) begin
      unique case (phase_r)
        PH_FILE: begin
          pos_nxt = pos_inc;
          unique case (pos_r[3:0])
            4'd0:    blue_nxt = file_byte;
            4'd1:    green_nxt = file_byte;
            4'd10:   offset_nxt[7:0] = file_byte;
            4'd11:   offset_nxt[15:8] = file_byte;
            4'd12:   offset_nxt[23:16] = file_byte;
            4'd13:   offset_nxt[31:24] = file_byte;
            default: ;
          endcase
          if (pos_r[3:0] == FILE_HDR_LAST) begin
            priority if (blue_r != MAGIC_B || green_r != MAGIC_M) status = ST_BAD_MAGIC;
            else if (offset_nxt < OFFSET_MIN) status = ST_BAD_OFFSET;
            else if (file_end) status = ST_SHORT_HDR;
            else begin
              phase_nxt = PH_INFO;
              blue_nxt  = '0;
              green_nxt = '0;
            end
          end else if (file_end) begin
            status = ST_SHORT_HDR;
          end
        end

        PH_INFO: begin
          pos_nxt = pos_inc;
          if (info_idx < 6'd4) begin
            hdr_size_nxt[8*info_idx[1:0] +: 8] = file_byte;
          end else if (hdr_small) begin
            unique case (info_idx)
              6'd4:    width_nxt[7:0] = file_byte;
              6'd5:    width_nxt[15:8] = file_byte;
              6'd6:    height_nxt[7:0] = file_byte;
              6'd7:    height_nxt[15:8] = file_byte;
              6'd10:   bpp_nxt[7:0] = file_byte;
              6'd11:   bpp_nxt[15:8] = file_byte;
              default: ;
            endcase
          end else begin
            unique case (info_idx)
              6'd4, 6'd5, 6'd6, 6'd7:
                width_nxt[8*info_idx[1:0] +: 8] = file_byte;
              6'd8, 6'd9, 6'd10, 6'd11:
                height_nxt[8*info_idx[1:0] +: 8] = file_byte;
              6'd14, 6'd15:
                bpp_nxt[8*info_idx[0] +: 8] = file_byte;
              6'd16, 6'd17, 6'd18, 6'd19:
                comp_nxt = comp_r | (|file_byte);
              default: ;
            endcase
          end
          if (info_idx == INFO_HDR_LAST) begin
            priority if (!hdr_small && comp_r) status = ST_COMPRESSED;
            else if (size_bad) status = ST_BAD_SIZE;
            else if (file_end) status = ST_SHORT_PIXEL;
            else begin
              row_bytes_nxt = {rb_words[13:0], 2'b00};
              phase_nxt     = (offset_r == OFFSET_MIN) ? PH_PIX : PH_SKIP;
            end
            comp_nxt = 1'b0;
          end else if (file_end) begin
            status = ST_SHORT_HDR;
          end
        end

        PH_SKIP: begin
          pos_nxt = pos_inc;
          priority if (file_end) status = ST_SHORT_PIXEL;
          else if (pos_inc == offset_r) phase_nxt = PH_PIX;
        end

        PH_PIX: begin
          if (in_pix) begin
            unique case (sub_r)
              13'd0:   blue_nxt = file_byte;
              13'd1:   green_nxt = file_byte;
              default: ;
            endcase
            if (sub_last) begin
              sub_nxt = '0;
              col_nxt = col_r + COL_W'(1);
            end else begin
              sub_nxt = sub_r + 13'd1;
            end
          end
          if (row_end) begin
            bir_nxt        = '0;
            sub_nxt        = '0;
            col_nxt        = '0;
            stored_row_nxt = stored_row_r + ROW_W'(1);
            complete       = (srow_h + HGT_W'(1)) >= height_h;
          end else begin
            bir_nxt = bir_r + 16'd1;
          end
          if (file_end && !complete) begin
            status = ST_SHORT_PIXEL;
          end else if (pixel) begin
            res_valid      = 1'b1;
            res.blue       = blue_r;
            res.green      = green_r;
            res.red        = file_byte;
            res.column     = 12'(col_r);
            res.image_row  = 12'(height_h - srow_h - HGT_W'(1));
            res.last_pixel = ((srow_h + HGT_W'(1)) == height_h)
                          && ((col_r + COL_W'(1)) == width_c);
            res.status     = ST_PIXEL;
          end
          if (complete) phase_nxt = PH_DRAIN;
        end

        PH_DRAIN: ;

        default: ;
      endcase

      if (status != ST_PIXEL) begin
        res_valid  = 1'b1;
        res        = '0;
        res.status = status;
        phase_nxt  = PH_DRAIN;
      end

      if (file_end) begin
        phase_nxt      = PH_FILE;
        pos_nxt        = '0;
        offset_nxt     = '0;
        hdr_size_nxt   = '0;
        width_nxt      = '0;
        height_nxt     = '0;
        bpp_nxt        = '0;
        row_bytes_nxt  = '0;
        bir_nxt        = '0;
        stored_row_nxt = '0;
        blue_nxt       = '0;
        green_nxt      = '0;
        comp_nxt       = 1'b0;
        sub_nxt        = '0;
        col_nxt        = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FILE;
      pos_r        <= '0;
      offset_r     <= '0;
      hdr_size_r   <= '0;
      width_r      <= '0;
      height_r     <= '0;
      bpp_r        <= '0;
      row_bytes_r  <= '0;
      bir_r        <= '0;
      stored_row_r <= '0;
      blue_r       <= '0;
      green_r      <= '0;
      comp_r       <= 1'b0;
      sub_r        <= '0;
      col_r        <= '0;
    end else begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      offset_r     <= offset_nxt;
      hdr_size_r   <= hdr_size_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      bpp_r        <= bpp_nxt;
      row_bytes_r  <= row_bytes_nxt;
      bir_r        <= bir_nxt;
      stored_row_r <= stored_row_nxt;
      blue_r       <= blue_nxt;
      green_r      <= green_nxt;
      comp_r       <= comp_nxt;
      sub_r        <= sub_nxt;
      col_r        <= col_nxt;
    end
  end

endmodule

// ===== hw/rtl/bmpx_out_buf.sv =====
// Two-entry result buffer: output register plus skid register, so a stalled
// consumer does not block bytes that give no result. Depends on bmpx_pkg.
module bmpx_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bmpx_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output bmpx_pkg::result_t out_data
);
  import bmpx_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    take;

  assign take      = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

// ===== hw/rtl/bmp_stream_pixel_extractor.sv =====
// Top level of the BMP pixel extractor: parser and result buffer.
// Depends on bmpx_pkg, bmpx_parser and bmpx_out_buf.
//
// Takes one file byte per clock while in_stall is low. Each byte updates the
// header and row state; a pixel or error item is registered into the output
// register, or the skid register if that one is still held. A two-entry
// output buffer lets bytes keep flowing while one result waits; in_stall
// rises only when both entries hold results. Row length is worked out once,
// on the last info header byte, by one 16 by 13 bit multiply. No clearing
// pass after reset: bytes are taken as soon as reset is released.
module bmp_stream_pixel_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_file_byte,
  input  logic        in_file_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [11:0] out_column,
  output logic [11:0] out_image_row,
  output logic        out_last_pixel,
  output logic [2:0]  out_status
);
  import bmpx_pkg::*;

  logic    in_accept;
  logic    res_valid;
  result_t res;
  result_t out_data;
  logic    buf_full;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = buf_full;

  bmpx_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .file_byte (in_file_byte),
    .file_end  (in_file_end),
    .res_valid (res_valid),
    .res       (res)
  );

  bmpx_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_blue       = out_data.blue;
  assign out_green      = out_data.green;
  assign out_red        = out_data.red;
  assign out_column     = out_data.column;
  assign out_image_row  = out_data.image_row;
  assign out_last_pixel = out_data.last_pixel;
  assign out_status     = out_data.status;

  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_PIXEL) |->
      (out_blue == 8'd0 && out_green == 8'd0 && out_red == 8'd0 &&
       out_column == 12'd0 && out_image_row == 12'd0 && !out_last_pixel))
    else $error("error item carries nonzero pixel fields");

  a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_pixel) |-> (out_status == ST_PIXEL))
    else $error("last pixel flag on an error item");

endmodule
